@@ rtl/core/accumulator_machine_executor_unit_macros.svh @@
// ----------------------------------------------------------------------------
// accumulator machine executor assertion macros
// shared property templates for the port checker
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_MACHINE_EXECUTOR_UNIT_MACROS_SVH
`define ACCUMULATOR_MACHINE_EXECUTOR_UNIT_MACROS_SVH

// same-cycle implication
`define AMX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("amx check failed");

// next-cycle implication
`define AMX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("amx check failed");

`endif

@@ rtl/core/amx_pkg.sv @@
// ----------------------------------------------------------------------------
// amx_pkg
// types and constants of the accumulator machine executor
// ----------------------------------------------------------------------------
package amx_pkg;

  localparam int unsigned ADDR_SPAN   = 256;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [63:0] UC_EXECUTE  = 64'd2;

  typedef enum logic [3:0] {
    OP_SET   = 4'd0,
    OP_LDR   = 4'd1,
    OP_ADD   = 4'd2,
    OP_INC   = 4'd3,
    OP_DEC   = 4'd4,
    OP_STR   = 4'd5,
    OP_SHW   = 4'd6,
    OP_PAUSE = 4'd7,
    OP_END   = 4'd8
  } op_e;

  typedef enum logic [2:0] {
    SHOW_ACC = 3'd0,
    SHOW_ICR = 3'd1,
    SHOW_MAR = 3'd2,
    SHOW_MDR = 3'd3,
    SHOW_UC  = 3'd4,
    SHOW_MEM = 3'd5
  } show_e;

  typedef enum logic [3:0] {
    K_NOP,
    K_SETI,
    K_SETM,
    K_LDR,
    K_ADD1,
    K_ADD2,
    K_INC,
    K_DEC,
    K_STR,
    K_SHWM
  } kind_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RD1,
    BK_RD2,
    BK_FIN
  } bk_state_e;

  typedef struct packed {
    logic [3:0]         operation;
    logic [7:0]         addr_a;
    logic [7:0]         addr_b;
    logic [7:0]         addr_c;
    logic               has_b;
    logic               has_c;
    logic               set_from_memory;
    logic signed [63:0] immediate;
    logic [2:0]         show_select;
  } amx_in_t;

  typedef struct packed {
    logic               show_valid;
    logic signed [63:0] shown_value;
    logic signed [63:0] accumulator_value;
    logic [15:0]        instr_counter;
    logic               paused;
    logic               halted;
  } amx_out_t;

  // classified word passed from front to back
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  idx_a;
    logic [7:0]  idx_b;
    logic [7:0]  idx_c;
    logic [63:0] immediate;
    logic        store_c;
    logic        show_en;
    show_e       show_sel;
    logic        paused;
    logic        halted;
    logic [15:0] fetch_count;
  } amx_word_t;

endpackage

@@ rtl/core/accumulator_machine_executor_unit.sv @@
// ----------------------------------------------------------------------------
// accumulator_machine_executor_unit
// executes decoded accumulator machine instructions against a data memory
// ----------------------------------------------------------------------------
// usage:
//   in channel: one decoded instruction word per handshake (in_word_i)
//   out channel: exactly one result word per instruction, in order
//   the front takes a word whenever the two-entry queue has room, so it
//   keeps accepting while the back executes or the result waits
//   back: words without a memory read pass idle and fin; a read, or a read
//   then write, adds rd1; the two-source add adds rd1 and rd2, as the
//   single memory port takes one access per state
//   reset: the data memory is cleared one word per cycle, all MEM_DEPTH
//   words, and in_ready_o stays low until that pass is done
//   receiver stall: the result register holds its word; the back then
//   stops, the queue fills and in_ready_o drops
// ----------------------------------------------------------------------------
module accumulator_machine_executor_unit #(
  parameter int unsigned MEM_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  amx_pkg::amx_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output amx_pkg::amx_out_t out_word_o
);
  import amx_pkg::*;

  logic      q_push, q_ready, q_valid, q_pop, clr_done;
  amx_word_t push_word, head_word;

  amx_front #(
    .MEM_DEPTH(MEM_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .q_ready_i  (q_ready),
    .clr_done_i (clr_done),
    .q_push_o   (q_push),
    .q_word_o   (push_word)
  );

  amx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .word_i  (push_word),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .word_o  (head_word)
  );

  amx_back #(
    .MEM_DEPTH(MEM_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_word_i    (head_word),
    .q_pop_o     (q_pop),
    .clr_done_o  (clr_done),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

@@ rtl/core/amx_front.sv @@
// ----------------------------------------------------------------------------
// amx_front
// accepts words, wraps addresses, counts fetches, tracks halt, classifies
// ----------------------------------------------------------------------------
module amx_front #(
  parameter int unsigned MEM_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  amx_pkg::amx_in_t   in_word_i,
  input  logic               q_ready_i,
  input  logic               clr_done_i,
  output logic               q_push_o,
  output amx_pkg::amx_word_t q_word_o
);
  import amx_pkg::*;

  logic [7:0]  wrap_tbl [ADDR_SPAN];
  logic [15:0] fc_q, fc_d;
  logic        halt_q;
  amx_word_t   word;

  for (genvar i = 0; i < ADDR_SPAN; i++) begin : g_wrap
    assign wrap_tbl[i] = 8'(i % MEM_DEPTH);
  end

  always_comb begin
    fc_d             = (fc_q == 16'hFFFF) ? fc_q : fc_q + 16'd1;
    word             = '0;
    word.kind        = K_NOP;
    word.idx_a       = wrap_tbl[in_word_i.addr_a];
    word.idx_b       = wrap_tbl[in_word_i.addr_b];
    word.idx_c       = wrap_tbl[in_word_i.addr_c];
    word.immediate   = in_word_i.immediate;
    word.show_sel    = show_e'(in_word_i.show_select);
    word.halted      = halt_q;
    word.fetch_count = fc_q;
    if (!halt_q) begin
      word.fetch_count = fc_d;
      case (op_e'(in_word_i.operation))
        OP_SET: begin
          word.kind = in_word_i.set_from_memory ? K_SETM : K_SETI;
        end
        OP_LDR: word.kind = K_LDR;
        OP_ADD: begin
          word.kind    = in_word_i.has_b ? K_ADD2 : K_ADD1;
          word.store_c = in_word_i.has_b & in_word_i.has_c;
        end
        OP_INC: word.kind = K_INC;
        OP_DEC: word.kind = K_DEC;
        OP_STR: word.kind = K_STR;
        OP_SHW: begin
          case (show_e'(in_word_i.show_select))
            SHOW_ACC, SHOW_ICR, SHOW_MAR, SHOW_MDR, SHOW_UC: word.show_en = 1'b1;
            SHOW_MEM: begin
              word.show_en = 1'b1;
              word.kind    = K_SHWM;
            end
            default: word.show_en = 1'b0;
          endcase
        end
        OP_PAUSE: word.paused = 1'b1;
        OP_END:   word.halted = 1'b1;
        default:  word.kind   = K_NOP;
      endcase
    end
  end

  assign in_ready_o = q_ready_i & clr_done_i;
  assign q_push_o   = in_valid_i & in_ready_o;
  assign q_word_o   = word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q   <= '0;
      halt_q <= 1'b0;
    end else if (q_push_o) begin
      fc_q   <= word.fetch_count;
      halt_q <= word.halted;
    end
  end

endmodule

@@ rtl/core/amx_queue.sv @@
// ----------------------------------------------------------------------------
// amx_queue
// short register queue between front and back
// ----------------------------------------------------------------------------
module amx_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  amx_pkg::amx_word_t word_i,
  output logic               ready_o,
  input  logic               pop_i,
  output logic               valid_o,
  output amx_pkg::amx_word_t word_o
);
  import amx_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  amx_word_t         slot_q [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]     count_q;

  assign ready_o = (count_q != CW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign word_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

@@ rtl/core/amx_back.sv @@
// ----------------------------------------------------------------------------
// amx_back
// sequencer over the single-port data memory, accumulator, mar, mdr and
// the result register
// ----------------------------------------------------------------------------
module amx_back #(
  parameter int unsigned MEM_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  amx_pkg::amx_word_t q_word_i,
  output logic               q_pop_o,
  output logic               clr_done_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output amx_pkg::amx_out_t  out_word_o
);
  import amx_pkg::*;

  localparam int unsigned AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic [63:0]   mem [MEM_DEPTH];
  logic [63:0]   rdata_q;

  bk_state_e     state_q, state_d;
  logic [AW-1:0] clr_cnt_q;
  amx_word_t     cur_q;
  logic [63:0]   acc_q, mdr_q, tmp_q;
  logic [7:0]    mar_q;
  logic          out_valid_q;
  amx_out_t      out_q;

  logic          mem_we, mem_re, out_load;
  logic [7:0]    acc_idx;
  logic [AW-1:0] mem_addr;
  logic [63:0]   mem_wdata, shown;

  // memory control and datapath selects
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    acc_idx   = '0;
    mem_wdata = '0;
    q_pop_o   = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      BK_CLEAR: mem_we = 1'b1;
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_word_i.kind)
            K_SETM: begin
              mem_re  = 1'b1;
              acc_idx = q_word_i.idx_b;
            end
            K_LDR, K_ADD1, K_ADD2, K_INC, K_DEC, K_SHWM: begin
              mem_re  = 1'b1;
              acc_idx = q_word_i.idx_a;
            end
            K_SETI: begin
              mem_we    = 1'b1;
              acc_idx   = q_word_i.idx_a;
              mem_wdata = q_word_i.immediate;
            end
            K_STR: begin
              mem_we    = 1'b1;
              acc_idx   = q_word_i.idx_a;
              mem_wdata = acc_q;
            end
            default: mem_we = 1'b0;
          endcase
        end
      end
      BK_RD1: begin
        case (cur_q.kind)
          K_SETM: begin
            mem_we    = 1'b1;
            acc_idx   = cur_q.idx_a;
            mem_wdata = rdata_q;
          end
          K_INC: begin
            mem_we    = 1'b1;
            acc_idx   = cur_q.idx_a;
            mem_wdata = rdata_q + 64'd1;
          end
          K_DEC: begin
            mem_we    = 1'b1;
            acc_idx   = cur_q.idx_a;
            mem_wdata = rdata_q - 64'd1;
          end
          K_ADD2: begin
            mem_re  = 1'b1;
            acc_idx = cur_q.idx_b;
          end
          default: mem_we = 1'b0;
        endcase
      end
      BK_RD2: begin
        mem_we    = cur_q.store_c;
        acc_idx   = cur_q.idx_c;
        mem_wdata = tmp_q + rdata_q;
      end
      BK_FIN: out_load = !out_valid_q || out_ready_i;
      default: mem_we = 1'b0;
    endcase
  end

  assign mem_addr = (state_q == BK_CLEAR) ? clr_cnt_q : AW'(acc_idx);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_CLEAR: begin
        if (clr_cnt_q == AW'(MEM_DEPTH - 1)) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid_i) begin
          state_d = mem_re ? BK_RD1 : BK_FIN;
        end
      end
      BK_RD1:  state_d = (cur_q.kind == K_ADD2) ? BK_RD2 : BK_FIN;
      BK_RD2:  state_d = BK_FIN;
      BK_FIN: begin
        if (out_load) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    shown = '0;
    if (cur_q.show_en) begin
      case (cur_q.show_sel)
        SHOW_ACC: shown = acc_q;
        SHOW_ICR: shown = 64'(cur_q.fetch_count);
        SHOW_MAR: shown = 64'(mar_q);
        SHOW_MDR: shown = mdr_q;
        SHOW_UC:  shown = UC_EXECUTE;
        SHOW_MEM: shown = tmp_q;
        default:  shown = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_word_i;
    end
    if (state_q == BK_RD1) begin
      tmp_q <= rdata_q;
    end
    if (out_load) begin
      out_q.show_valid        <= cur_q.show_en;
      out_q.shown_value       <= shown;
      out_q.accumulator_value <= acc_q;
      out_q.instr_counter     <= cur_q.fetch_count;
      out_q.paused            <= cur_q.paused;
      out_q.halted            <= cur_q.halted;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_cnt_q   <= '0;
      acc_q       <= '0;
      mar_q       <= '0;
      mdr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (state_q == BK_RD1) begin
        case (cur_q.kind)
          K_LDR:   acc_q <= rdata_q;
          K_ADD1:  acc_q <= acc_q + rdata_q;
          default: acc_q <= acc_q;
        endcase
      end
      if (state_q == BK_RD2) begin
        acc_q <= tmp_q + rdata_q;
      end
      // a write outside the clear pass always leaves its own address and data
      if (mem_we && state_q != BK_CLEAR) begin
        mar_q <= acc_idx;
        mdr_q <= mem_wdata;
      end else if (state_q == BK_RD1) begin
        mar_q <= cur_q.idx_a;
        mdr_q <= rdata_q;
      end else if (state_q == BK_RD2) begin
        mar_q <= cur_q.idx_b;
        mdr_q <= rdata_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign clr_done_o  = (state_q != BK_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

@@ rtl/core/amx_checker.sv @@
// ----------------------------------------------------------------------------
// amx_checker
// port-level checks of the accumulator machine executor
// ----------------------------------------------------------------------------
`include "accumulator_machine_executor_unit_macros.svh"

module amx_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input amx_pkg::amx_in_t  in_word_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input amx_pkg::amx_out_t out_word_o
);
  import amx_pkg::*;

  // offered word holds until taken
  `AMX_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o, in_valid_i && $stable(in_word_i))

  // stalled result holds
  `AMX_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_word_o))

  // nothing shown means zero shown
  `AMX_ASSERT_NOW(a_show_zero, clk_i, rst_ni, out_valid_o && !out_word_o.show_valid, out_word_o.shown_value == 64'd0)

  // a halted machine neither shows nor pauses
  `AMX_ASSERT_NOW(a_halt_quiet, clk_i, rst_ni, out_valid_o && out_word_o.halted, !out_word_o.show_valid && !out_word_o.paused)

  // memory clearing blocks input right after reset
  `AMX_ASSERT_NOW(a_clear_block, clk_i, rst_ni, $rose(rst_ni), !in_ready_o)

endmodule

bind accumulator_machine_executor_unit amx_checker u_amx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

@@ tb/amx_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amx_result_checker
// watches both channels of the accumulator machine executor, runs its own
// model of the machine on every accepted instruction word and compares each
// result word, field by field, with the oldest expected one
// ----------------------------------------------------------------------------
module amx_result_checker import amx_pkg::*; #(
  parameter int unsigned MEM_DEPTH = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  amx_in_t  in_word_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  amx_out_t out_word_i,
  output int       pending_o,
  output int       fail_count_o
);

  logic [63:0] mem_model [MEM_DEPTH];
  logic [63:0] acc_q;
  logic [63:0] mdr_q;
  logic [15:0] icr_q;
  logic [7:0]  mar_q;
  logic        halt_q;
  amx_out_t    expected_results [$];
  int          errors;

  function automatic logic [63:0] mem_rd(input logic [7:0] addr);
    int unsigned idx;
    idx   = int'(addr) % MEM_DEPTH;
    mar_q = idx[7:0];
    mdr_q = mem_model[idx];
    return mdr_q;
  endfunction

  function automatic void mem_wr(input logic [7:0] addr, input logic [63:0] value);
    int unsigned idx;
    idx            = int'(addr) % MEM_DEPTH;
    mem_model[idx] = value;
    mar_q          = idx[7:0];
    mdr_q          = value;
  endfunction

  function automatic amx_out_t execute_instr(input amx_in_t w);
    amx_out_t    r;
    logic [63:0] lhs;
    logic [63:0] rhs;
    r = '0;
    if (!halt_q) begin
      if (icr_q != 16'hffff) icr_q = icr_q + 16'd1;
      case (w.operation)
        OP_SET: begin
          if (w.set_from_memory) lhs = mem_rd(w.addr_b);
          else lhs = w.immediate;
          mem_wr(w.addr_a, lhs);
        end
        OP_LDR: acc_q = mem_rd(w.addr_a);
        OP_ADD: begin
          if (!w.has_b) begin
            lhs   = mem_rd(w.addr_a);
            acc_q = acc_q + lhs;
          end else begin
            lhs   = mem_rd(w.addr_a);
            rhs   = mem_rd(w.addr_b);
            acc_q = lhs + rhs;
            if (w.has_c) mem_wr(w.addr_c, acc_q);
          end
        end
        OP_INC: begin
          lhs = mem_rd(w.addr_a) + 64'd1;
          mem_wr(w.addr_a, lhs);
        end
        OP_DEC: begin
          lhs = mem_rd(w.addr_a) - 64'd1;
          mem_wr(w.addr_a, lhs);
        end
        OP_STR: mem_wr(w.addr_a, acc_q);
        OP_SHW: begin
          r.show_valid = 1'b1;
          case (w.show_select)
            SHOW_ACC: r.shown_value = acc_q;
            SHOW_ICR: r.shown_value = {48'd0, icr_q};
            SHOW_MAR: r.shown_value = {56'd0, mar_q};
            SHOW_MDR: r.shown_value = mdr_q;
            SHOW_UC:  r.shown_value = UC_EXECUTE;
            SHOW_MEM: r.shown_value = mem_rd(w.addr_a);
            default:  r.show_valid  = 1'b0;
          endcase
        end
        OP_PAUSE: r.paused = 1'b1;
        OP_END:   halt_q   = 1'b1;
        default: ;
      endcase
    end
    r.accumulator_value = acc_q;
    r.instr_counter     = icr_q;
    r.halted            = halt_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      if (errors < 40) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      end
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    amx_out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MEM_DEPTH; i++) mem_model[i] = '0;
      acc_q  = '0;
      mdr_q  = '0;
      icr_q  = '0;
      mar_q  = '0;
      halt_q = 1'b0;
      errors = 0;
      expected_results.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result word with nothing expected, expected none, actual %h",
                   $time, out_word_i);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("show_valid", want.show_valid, out_word_i.show_valid);
          check_field("shown_value", want.shown_value, out_word_i.shown_value);
          check_field("accumulator_value", want.accumulator_value,
                      out_word_i.accumulator_value);
          check_field("instr_counter", want.instr_counter, out_word_i.instr_counter);
          check_field("paused", want.paused, out_word_i.paused);
          check_field("halted", want.halted, out_word_i.halted);
        end
      end
      if (in_valid_i && in_ready_i) expected_results.push_back(execute_instr(in_word_i));
      pending_o    <= expected_results.size();
      fail_count_o <= errors;
    end
  end

endmodule

@@ tb/tb_accumulator_machine_executor_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accumulator_machine_executor_unit
// drives directed and random instruction words into the executor with random
// idling on both channels, a long receiver hold-off and a tail after halt;
// the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_accumulator_machine_executor_unit;
  import amx_pkg::*;

  localparam int unsigned MEM_DEPTH   = ADDR_SPAN;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned RAND_WORDS  = 1250;
  localparam int unsigned HOLD_START  = 1500;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam logic [63:0] MAX_POS     = {1'b0, {63{1'b1}}};
  localparam logic [63:0] MIN_NEG     = {1'b1, 63'd0};

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  amx_in_t  in_word_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  amx_out_t out_word_o;

  logic        calm       = 1'b0;
  int unsigned cycle_cnt  = 0;
  int unsigned hold_left  = 0;
  int unsigned sent_count = 0;
  int unsigned show_count = 0;
  int          pending;
  int          fail_count;

  accumulator_machine_executor_unit #(
    .MEM_DEPTH(MEM_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  amx_result_checker #(
    .MEM_DEPTH(MEM_DEPTH)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_i  (out_word_o),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off
  always @(posedge clk_i) begin
    if (cycle_cnt == HOLD_START) hold_left = HOLD_CYCLES;
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (calm) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 8);
    end
  end

  function automatic amx_in_t make_instr(input logic [3:0] op, input logic [7:0] a,
                                         input logic [7:0] b, input logic [7:0] c,
                                         input logic hb, input logic hc, input logic fm,
                                         input logic [63:0] imm, input logic [2:0] sel);
    amx_in_t w;
    w.operation       = op;
    w.addr_a          = a;
    w.addr_b          = b;
    w.addr_c          = c;
    w.has_b           = hb;
    w.has_c           = hc;
    w.set_from_memory = fm;
    w.immediate       = imm;
    w.show_select     = sel;
    return w;
  endfunction

  // mostly a few hot addresses so values build up
  function automatic logic [7:0] pick_addr();
    if ($urandom_range(99) < 75) return 8'($urandom_range(7));
    return 8'($urandom_range(255));
  endfunction

  function automatic amx_in_t rand_instr();
    amx_in_t w;
    if ($urandom_range(99) < 4) begin
      w.operation = 4'($urandom_range(int'(OP_END) + 1, 15));
    end else begin
      w.operation = 4'($urandom_range(int'(OP_SET), int'(OP_PAUSE)));
    end
    w.addr_a          = pick_addr();
    w.addr_b          = pick_addr();
    w.addr_c          = pick_addr();
    w.has_b           = 1'($urandom_range(1));
    w.has_c           = 1'($urandom_range(1));
    w.set_from_memory = 1'($urandom_range(1));
    w.show_select     = 3'($urandom_range(7));
    case ($urandom_range(9))
      0:       w.immediate = 64'($signed($urandom_range(16)) - 8);
      1: begin
        case ($urandom_range(3))
          0:       w.immediate = MIN_NEG;
          1:       w.immediate = MAX_POS;
          2:       w.immediate = '1;
          default: w.immediate = '0;
        endcase
      end
      default: w.immediate = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  task automatic send_word(input amx_in_t w);
    int unsigned gap;
    if (!calm && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count++;
    if (w.operation == OP_SHW) show_count++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    amx_in_t w;
    int unsigned halted_words;
    halted_words = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, wrapping, every form and show target
    send_word(make_instr(OP_SET, 8'd255, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, MAX_POS, SHOW_ACC));
    send_word(make_instr(OP_SET, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, MIN_NEG, SHOW_ACC));
    send_word(make_instr(OP_SET, 8'd1, 8'd255, 8'd0, 1'b0, 1'b0, 1'b1, '1, SHOW_ACC));
    send_word(make_instr(OP_LDR, 8'd255, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0, SHOW_ACC));
    send_word(make_instr(OP_ADD, 8'd255, 8'd0, 8'd2, 1'b0, 1'b1, 1'b0, '0, SHOW_ACC));
    send_word(make_instr(OP_ADD, 8'd255, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0, '0, SHOW_ACC));
    send_word(make_instr(OP_ADD, 8'd0, 8'd0, 8'd3, 1'b1, 1'b1, 1'b0, '0, SHOW_ACC));
    send_word(make_instr(OP_INC, 8'd255, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0, SHOW_ACC));
    send_word(make_instr(OP_DEC, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0, SHOW_ACC));
    send_word(make_instr(OP_DEC, 8'd4, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0, SHOW_ACC));
    send_word(make_instr(OP_INC, 8'd4, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0, SHOW_ACC));
    send_word(make_instr(OP_STR, 8'd5, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0, SHOW_ACC));
    send_word(make_instr(OP_SHW, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0, SHOW_ACC));
    send_word(make_instr(OP_SHW, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0, SHOW_ICR));
    send_word(make_instr(OP_SHW, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0, SHOW_MAR));
    send_word(make_instr(OP_SHW, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0, SHOW_MDR));
    send_word(make_instr(OP_SHW, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0, SHOW_UC));
    send_word(make_instr(OP_SHW, 8'd255, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0, SHOW_MEM));
    send_word(make_instr(OP_SHW, 8'd1, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0, 3'(int'(SHOW_MEM) + 1)));
    send_word(make_instr(OP_SHW, 8'd1, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0, '1));
    send_word(make_instr(OP_PAUSE, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0, SHOW_ACC));
    send_word(make_instr(4'(int'(OP_END) + 1), 8'd7, 8'd7, 8'd7, 1'b1, 1'b1, 1'b1, '1, '1));
    send_word(make_instr('1, 8'd9, 8'd9, 8'd9, 1'b0, 1'b0, 1'b0, '0, SHOW_ACC));
    drain();

    for (int unsigned i = 0; i < RAND_WORDS; i++) begin
      if (i == 300) calm <= 1'b1;
      if (i == 600) calm <= 1'b0;
      if (i == 900) drain();
      send_word(rand_instr());
    end
    for (int i = 0; i < 60; i++) send_word(rand_instr());

    w = rand_instr();
    w.operation = OP_END;
    send_word(w);
    for (int i = 0; i < 12; i++) begin
      send_word(rand_instr());
      halted_words++;
    end
    drain();
    repeat (16) @(posedge clk_i);

    $display("covered %0d instruction words (%0d shows), wrapping arithmetic, all add forms,",
             sent_count, show_count);
    $display("a long output hold-off and %0d words after halt", halted_words);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
